// File: rtl/spf_pkg.sv
// package: shared constants, types and register codes for the pattern substitute block
`timescale 1ns / 1ps
`default_nettype none
package spf_pkg;

  localparam int MAX_PATTERN = 8;
  localparam int REPL_MAX    = 8;
  localparam int MAX_BURST   = (MAX_PATTERN > REPL_MAX) ? MAX_PATTERN : REPL_MAX;
  localparam int QDEPTH      = 2 * MAX_BURST;

  localparam int FILL_W  = $clog2(MAX_PATTERN + 1);
  localparam int BCNT_W  = $clog2(MAX_BURST + 1);
  localparam int BIDX_W  = (MAX_BURST > 1) ? $clog2(MAX_BURST) : 1;
  localparam int QCNT_W  = $clog2(QDEPTH + 1);
  localparam int CFG_W   = 64;
  localparam int CFG_IDX_W = 2;
  localparam int LEN_W   = 4;

  typedef logic [7:0] byte_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_BYTES  = 2'd0,
    CFG_PATTERN_LENGTH = 2'd1,
    CFG_REPL_BYTES     = 2'd2,
    CFG_REPL_LENGTH    = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    byte_t data;
    logic  bvalid;
    logic  last;
  } out_item_t;

  typedef struct packed {
    out_item_t [MAX_BURST-1:0] item;
    logic [BCNT_W-1:0]         n;
  } burst_t;

endpackage
`default_nettype wire

// File: rtl/spf_if.sv
// interfaces: text input channel and result channel
`timescale 1ns / 1ps
`default_nettype none
interface spf_in_if;
  logic  valid;
  logic  ready;
  logic [7:0] text_byte;
  logic  final_byte;
  modport source (output valid, output text_byte, output final_byte, input ready);
  modport sink   (input valid, input text_byte, input final_byte, output ready);
endinterface

interface spf_out_if;
  logic  valid;
  logic  ready;
  logic [7:0] out_byte;
  logic  byte_valid;
  logic  text_end;
  modport source (output valid, output out_byte, output byte_valid, output text_end,
                  input ready);
  modport sink   (input valid, input out_byte, input byte_valid, input text_end,
                  output ready);
endinterface
`default_nettype wire

// File: rtl/stream_pattern_substitute.sv
// top level: streaming find and replace over a byte stream
//
//   channel   dir   handshake          payload
//   in_ch     in    valid/ready        text_byte[7:0], final_byte
//   out_ch    out   valid/ready        out_byte[7:0], byte_valid, text_end
//   cfg       in    cfg_we (no ready)  cfg_index[1:0], cfg_wdata[63:0]
//
// one text byte is taken per cycle while the result queue holds at most 8 results
// a beat causes 0 to 8 results, drained one per cycle from the queue head while out_ch.ready
// a burst of n grows the backlog by n (n-1 if head pops); input stalls while more than 8 wait
// first result appears the cycle after its beat if the queue is empty, else behind older ones
// reset (synchronous, rst_n low) empties window and queue and loads register defaults
`timescale 1ns / 1ps
`default_nettype none
module stream_pattern_substitute
  import spf_pkg::*;
(
  input  wire                 clk,
  input  wire                 rst_n,
  spf_in_if.sink              in_ch,
  spf_out_if.source           out_ch,
  input  wire                 cfg_we,
  input  wire [CFG_IDX_W-1:0] cfg_index,
  input  wire [CFG_W-1:0]     cfg_wdata
);

  logic [CFG_W-1:0]  pat_bytes_r;
  logic [FILL_W-1:0] plen_r;
  logic [CFG_W-1:0]  repl_bytes_r;
  logic [BCNT_W-1:0] rlen_r;
  logic [FILL_W-1:0] fill_r;
  logic [FILL_W-1:0] fill_nxt;
  logic [FILL_W-1:0] fill_inc;
  logic [LEN_W-1:0]  wlen;

  logic accept, can_load, fin, full, match, shift;
  byte_t [MAX_PATTERN-1:0] cur;
  byte_t [MAX_PATTERN-1:0] right;
  byte_t [MAX_BURST-1:0]   wpad;
  logic  [MAX_PATTERN-1:0] eq;
  burst_t burst;

  assign fin      = in_ch.final_byte;
  assign accept   = in_ch.valid && can_load;
  assign in_ch.ready = can_load;
  assign fill_inc = fill_r + FILL_W'(1);
  assign full     = (fill_inc == plen_r);
  assign shift    = full && !match && !fin;
  assign wlen     = cfg_wdata[LEN_W-1:0];

  for (genvar g = 0; g < MAX_PATTERN; g++) begin : g_win
    if (g < MAX_PATTERN - 1) begin : g_mid
      assign right[g] = cur[g + 1];
    end else begin : g_end
      assign right[g] = '0;
    end
    spf_win_cell u_cell (
      .clk        (clk),
      .accept     (accept),
      .sel_new    (fill_r == FILL_W'(g)),
      .shift      (shift),
      .new_byte   (in_ch.text_byte),
      .right_byte (right[g]),
      .pat_byte   (pat_bytes_r[8*g +: 8]),
      .cur        (cur[g]),
      .eq         (eq[g])
    );
  end

  always_comb begin
    match = full;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      if ((FILL_W'(i) < plen_r) && !eq[i]) begin
        match = 1'b0;
      end
    end
  end

  always_comb begin
    for (int k = 0; k < MAX_BURST; k++) begin
      wpad[k] = '0;
    end
    for (int k = 0; k < MAX_PATTERN; k++) begin
      wpad[k] = cur[k];
    end
    if (match) begin
      burst.n = (fin && (rlen_r == '0)) ? BCNT_W'(1) : rlen_r;
    end else if (fin) begin
      burst.n = BCNT_W'(fill_inc);
    end else if (full) begin
      burst.n = BCNT_W'(1);
    end else begin
      burst.n = '0;
    end
    for (int k = 0; k < MAX_BURST; k++) begin
      burst.item[k].data   = match ? repl_bytes_r[8*k +: 8] : wpad[k];
      burst.item[k].bvalid = 1'b1;
      burst.item[k].last   = fin && (BCNT_W'(k + 1) == burst.n);
    end
    // empty replacement on the last byte leaves only an end marker
    if (match && fin && (rlen_r == '0)) begin
      burst.item[0].data   = '0;
      burst.item[0].bvalid = 1'b0;
    end
  end

  always_comb begin
    fill_nxt = fill_r;
    if (accept) begin
      if (match || fin) begin
        fill_nxt = '0;
      end else if (full) begin
        fill_nxt = plen_r - FILL_W'(1);
      end else begin
        fill_nxt = fill_inc;
      end
    end
    if (cfg_we && (cfg_idx_t'(cfg_index) == CFG_PATTERN_LENGTH)) begin
      fill_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_bytes_r  <= '0;
      plen_r       <= FILL_W'(1);
      repl_bytes_r <= '0;
      rlen_r       <= '0;
      fill_r       <= '0;
    end else begin
      fill_r <= fill_nxt;
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_PATTERN_BYTES: pat_bytes_r <= cfg_wdata;
          CFG_PATTERN_LENGTH: begin
            if (wlen == '0) begin
              plen_r <= FILL_W'(1);
            end else if (wlen > LEN_W'(MAX_PATTERN)) begin
              plen_r <= FILL_W'(MAX_PATTERN);
            end else begin
              plen_r <= FILL_W'(wlen);
            end
          end
          CFG_REPL_BYTES: repl_bytes_r <= cfg_wdata;
          CFG_REPL_LENGTH: begin
            if (wlen > LEN_W'(REPL_MAX)) begin
              rlen_r <= BCNT_W'(REPL_MAX);
            end else begin
              rlen_r <= BCNT_W'(wlen);
            end
          end
          default: ;
        endcase
      end
    end
  end

  spf_out_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (accept),
    .burst    (burst),
    .can_load (can_load),
    .out_ch   (out_ch)
  );

endmodule
`default_nettype wire

// File: rtl/spf_win_cell.sv
// window cell: one held text byte, new-byte insert, pattern compare, shift to left neighbor
`timescale 1ns / 1ps
`default_nettype none
module spf_win_cell
  import spf_pkg::*;
(
  input  wire   clk,
  input  wire   accept,
  input  wire   sel_new,
  input  wire   shift,
  input  byte_t new_byte,
  input  byte_t right_byte,
  input  byte_t pat_byte,
  output byte_t cur,
  output logic  eq
);

  byte_t data_r;
  byte_t data_nxt;

  assign cur = sel_new ? new_byte : data_r;
  assign eq  = (cur == pat_byte);

  always_comb begin
    data_nxt = data_r;
    if (accept) begin
      data_nxt = shift ? right_byte : cur;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule
`default_nettype wire

// File: rtl/spf_out_queue.sv
// result queue: row of result cells shifting toward the output, bursts appended at the tail
`timescale 1ns / 1ps
`default_nettype none
module spf_out_queue
  import spf_pkg::*;
(
  input  wire        clk,
  input  wire        rst_n,
  input  wire        load,
  input  burst_t     burst,
  output logic       can_load,
  spf_out_if.source  out_ch
);

  out_item_t [QDEPTH-1:0] q_r;
  out_item_t [QDEPTH-1:0] q_nxt;
  out_item_t [QDEPTH-1:0] sh;
  logic [QCNT_W-1:0] count_r;
  logic [QCNT_W-1:0] count_nxt;
  logic [QCNT_W-1:0] base;
  logic [QCNT_W-1:0] off;
  logic              pop;

  assign can_load = (count_r <= QCNT_W'(QDEPTH - MAX_BURST));
  assign out_ch.valid      = (count_r != '0);
  assign out_ch.out_byte   = q_r[0].data;
  assign out_ch.byte_valid = q_r[0].bvalid;
  assign out_ch.text_end   = q_r[0].last;

  always_comb begin
    pop  = (count_r != '0) && out_ch.ready;
    base = count_r - QCNT_W'(pop);
    off  = '0;
    for (int i = 0; i < QDEPTH - 1; i++) begin
      sh[i] = q_r[i + 1];
    end
    sh[QDEPTH-1] = q_r[QDEPTH-1];
    for (int i = 0; i < QDEPTH; i++) begin
      q_nxt[i] = q_r[i];
      if (QCNT_W'(i) < base) begin
        q_nxt[i] = pop ? sh[i] : q_r[i];
      end else begin
        off = QCNT_W'(i) - base;
        if (load && (off < QCNT_W'(burst.n))) begin
          q_nxt[i] = burst.item[off[BIDX_W-1:0]];
        end
      end
    end
    count_nxt = base + (load ? QCNT_W'(burst.n) : QCNT_W'(0));
  end

  always_ff @(posedge clk) begin
    q_r <= q_nxt;
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/spf_checker.sv
// checker: port-level properties of the pattern substitute block, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module spf_checker (
  input wire       clk,
  input wire       rst_n,
  input wire       in_ready,
  input wire       out_valid,
  input wire       out_ready,
  input wire [7:0] out_byte,
  input wire       byte_valid,
  input wire       text_end
);

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(byte_valid)
      && $stable(text_end))
    else $error("result changed while stalled");

  a_valid_drop: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_valid) |-> $past(out_ready))
    else $error("result withdrawn without beat");

  a_marker_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !byte_valid |-> text_end && (out_byte == 8'd0))
    else $error("marker beat without end or with data");

  a_ready_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> in_ready && !out_valid)
    else $error("not empty after reset");

endmodule

bind stream_pattern_substitute spf_checker u_spf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_byte   (out_ch.out_byte),
  .byte_valid (out_ch.byte_valid),
  .text_end   (out_ch.text_end)
);
`default_nettype wire

// File: tb/tb_stream_pattern_substitute.sv
// testbench: stream_pattern_substitute checked beat by beat against a find-and-replace predictor
`timescale 1ns / 1ps
module tb_stream_pattern_substitute;
  import spf_pkg::*;

  localparam int RESET_CYCLES  = 8;
  localparam int SETTLE_CYCLES = 6;
  localparam int QUIET_LIMIT   = 4000;
  localparam int MAX_TEXT      = 24;
  localparam int MAX_PRINTED   = 40;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_wdata;

  spf_in_if  text_if ();
  spf_out_if result_if ();

  stream_pattern_substitute i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (text_if),
    .out_ch    (result_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  // predictor state
  logic [63:0] pat_bytes;
  logic [3:0]  pat_len;
  logic [63:0] repl_bytes;
  logic [3:0]  repl_len;
  byte_t       held_bytes [MAX_PATTERN];
  int          held_count;
  out_item_t   expected_text_out [$];

  int   src_idle_pct;
  int   sink_stall_pct;
  int   items_sent;
  int   beats_checked;
  int   mismatches;
  int   quiet_cycles;
  bit   use_symbols;
  byte_t sym_a;
  byte_t sym_b;

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTED) $display("mismatch at %0t: %s", $time, msg);
  endtask

  function automatic int eff_pattern_len();
    if (pat_len == 0) return 1;
    if (pat_len > MAX_PATTERN) return MAX_PATTERN;
    return int'(pat_len);
  endfunction

  function automatic void shift_out_oldest(ref out_item_t burst[$]);
    int i;
    burst.push_back('{data: held_bytes[0], bvalid: 1'b1, last: 1'b0});
    for (i = 1; i < held_count; i++) held_bytes[i-1] = held_bytes[i];
    held_count--;
  endfunction

  function automatic void predict_substitution(input byte_t b, input bit fin);
    int plen;
    int rlen;
    int i;
    bit hit;
    out_item_t burst [$];
    plen = eff_pattern_len();
    rlen = (repl_len > REPL_MAX) ? REPL_MAX : int'(repl_len);
    if (held_count >= plen) held_count = plen - 1;
    held_bytes[held_count] = b;
    held_count++;
    hit = (held_count == plen);
    for (i = 0; i < plen; i++)
      if (held_bytes[i] != pat_bytes[8*i +: 8]) hit = 1'b0;
    if (hit) begin
      for (i = 0; i < rlen; i++)
        burst.push_back('{data: repl_bytes[8*i +: 8], bvalid: 1'b1, last: 1'b0});
      held_count = 0;
      if (fin && rlen == 0) burst.push_back('{data: 8'h00, bvalid: 1'b0, last: 1'b0});
    end else begin
      if (held_count == plen) shift_out_oldest(burst);
      if (fin) while (held_count > 0) shift_out_oldest(burst);
    end
    if (fin && burst.size() > 0) burst[burst.size()-1].last = 1'b1;
    foreach (burst[k]) expected_text_out.push_back(burst[k]);
  endfunction

  task automatic send_byte(input byte_t b, input bit fin);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      text_if.valid <= 1'b0;
      @(negedge clk);
    end
    text_if.valid      <= 1'b1;
    text_if.text_byte  <= b;
    text_if.final_byte <= fin;
    do @(posedge clk); while (!text_if.ready);
    predict_substitution(b, fin);
    items_sent++;
  endtask

  task automatic send_bytes(input logic [63:0] bytes, input int n, input bit fin);
    int i;
    for (i = 0; i < n; i++) send_byte(bytes[8*i +: 8], fin && (i == n - 1));
  endtask

  task automatic sender_rest();
    @(negedge clk);
    text_if.valid <= 1'b0;
  endtask

  task automatic wait_idle();
    sender_rest();
    while (expected_text_out.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [63:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_PATTERN_BYTES:  pat_bytes = val;
      CFG_PATTERN_LENGTH: begin
        pat_len    = val[3:0];
        held_count = 0;
      end
      CFG_REPL_BYTES:     repl_bytes = val;
      CFG_REPL_LENGTH:    repl_len = val[3:0];
      default: ;
    endcase
  endtask

  function automatic int pick_len(input int lo, input int hi);
    case ($urandom_range(9))
      0: return lo;
      1: return hi;
      2: return $urandom_range(15, 0);
      default: return $urandom_range(hi, lo);
    endcase
  endfunction

  task automatic randomize_settings();
    logic [63:0] pat;
    int i;
    wait_idle();
    use_symbols = 1'($urandom_range(1));
    sym_a = 8'($urandom);
    sym_b = 8'($urandom);
    pat = {$urandom, $urandom};
    if (use_symbols)
      for (i = 0; i < 8; i++) pat[8*i +: 8] = $urandom_range(1) ? sym_a : sym_b;
    write_reg(CFG_PATTERN_BYTES, pat);
    write_reg(CFG_PATTERN_LENGTH, 64'(pick_len(1, MAX_PATTERN)));
    write_reg(CFG_REPL_BYTES, {$urandom, $urandom});
    write_reg(CFG_REPL_LENGTH, 64'(pick_len(0, REPL_MAX)));
  endtask

  // text with embedded pattern copies, some cut short
  task automatic send_random_text(input int max_len);
    int len;
    int k;
    int j;
    int cut;
    int plen;
    byte_t b;
    len  = $urandom_range(max_len, 1);
    plen = eff_pattern_len();
    k = 0;
    while (k < len) begin
      if ($urandom_range(99) < 35) begin
        cut = ($urandom_range(4) == 0) ? $urandom_range(plen, 1) : plen;
        for (j = 0; j < cut && k < len; j++) begin
          send_byte(pat_bytes[8*j +: 8], k == len - 1);
          k++;
        end
      end else begin
        if (use_symbols && $urandom_range(4) != 0) b = $urandom_range(1) ? sym_a : sym_b;
        else b = 8'($urandom);
        send_byte(b, k == len - 1);
        k++;
      end
    end
  endtask

  task automatic test_reset_defaults();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
  endtask

  task automatic test_full_width_match();
    wait_idle();
    write_reg(CFG_PATTERN_BYTES, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(CFG_PATTERN_LENGTH, 64'd8);
    write_reg(CFG_REPL_BYTES, 64'h0123_4567_89AB_CDEF);
    write_reg(CFG_REPL_LENGTH, 64'd8);
    send_bytes(64'hFFFF_FFFF_FFFF_FFFF, 8, 1'b1);
  endtask

  task automatic test_partial_flush();
    send_bytes(64'h0000_0000_00FF_FFFF, 3, 1'b1);
  endtask

  task automatic test_length_clamp();
    wait_idle();
    write_reg(CFG_PATTERN_LENGTH, 64'd0);
    write_reg(CFG_REPL_LENGTH, 64'd15);
    send_byte(8'hFF, 1'b1);
    wait_idle();
    write_reg(CFG_PATTERN_LENGTH, 64'd15);
    send_bytes(64'h0000_0000_0000_807F, 2, 1'b1);
  endtask

  // held bytes are dropped by a pattern length write
  task automatic test_length_change_mid_text();
    wait_idle();
    write_reg(CFG_PATTERN_BYTES, 64'h0000_0000_4433_2211);
    write_reg(CFG_PATTERN_LENGTH, 64'd4);
    send_bytes(64'h0000_0000_0000_2211, 2, 1'b0);
    wait_idle();
    write_reg(CFG_PATTERN_LENGTH, 64'd4);
    send_byte(8'h33, 1'b1);
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int n_items);
    int stop_at;
    src_idle_pct   = idle_pct;
    sink_stall_pct = stall_pct;
    randomize_settings();
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      send_random_text(MAX_TEXT);
      case ($urandom_range(9))
        0: randomize_settings();
        1: wait_idle();
        default: ;
      endcase
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n && result_if.valid && result_if.ready) begin
      beats_checked++;
      if (expected_text_out.size() == 0) begin
        report_mismatch($sformatf("beat %0d unexpected: byte %02h valid %0b end %0b",
                                  beats_checked, result_if.out_byte, result_if.byte_valid,
                                  result_if.text_end));
      end else begin
        want = expected_text_out.pop_front();
        if (result_if.out_byte !== want.data)
          report_mismatch($sformatf("beat %0d out_byte %02h, want %02h",
                                    beats_checked, result_if.out_byte, want.data));
        if (result_if.byte_valid !== want.bvalid)
          report_mismatch($sformatf("beat %0d byte_valid %0b, want %0b",
                                    beats_checked, result_if.byte_valid, want.bvalid));
        if (result_if.text_end !== want.last)
          report_mismatch($sformatf("beat %0d text_end %0b, want %0b",
                                    beats_checked, result_if.text_end, want.last));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (text_if.valid && text_if.ready) || (result_if.valid && result_if.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles without a beat", quiet_cycles);
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    result_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      result_if.ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  initial begin
    int guard;
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = '0;
    cfg_wdata          = '0;
    text_if.valid      = 1'b0;
    text_if.text_byte  = 8'h00;
    text_if.final_byte = 1'b0;
    pat_bytes          = 64'd0;
    pat_len            = 4'd1;
    repl_bytes         = 64'd0;
    repl_len           = 4'd0;
    held_count         = 0;
    foreach (held_bytes[i]) held_bytes[i] = 8'h00;
    src_idle_pct       = 0;
    sink_stall_pct     = 0;
    items_sent         = 0;
    beats_checked      = 0;
    mismatches         = 0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_full_width_match();
    test_partial_flush();
    test_length_clamp();
    test_length_change_mid_text();
    test_random_traffic(0, 0, 110);
    test_random_traffic(71, 0, 110);
    test_random_traffic(0, 71, 110);
    test_random_traffic(6, 6, 110);

    sender_rest();
    guard = 0;
    while (expected_text_out.size() != 0 && guard < QUIET_LIMIT / 2) begin
      @(posedge clk);
      guard++;
    end
    repeat (4 * SETTLE_CYCLES) @(posedge clk);
    if (expected_text_out.size() != 0)
      report_mismatch($sformatf("%0d expected beats never arrived", expected_text_out.size()));
    if (mismatches == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

endmodule

// File: filelist.f
rtl/spf_pkg.sv
rtl/spf_if.sv
rtl/spf_win_cell.sv
rtl/spf_out_queue.sv
rtl/stream_pattern_substitute.sv
rtl/spf_checker.sv
tb/tb_stream_pattern_substitute.sv
